FILE: rtl/ising_metropolis_update_core_assert.svh
// Assertion macros used by the checker of the Ising update core.
// Both macros expect signals named clk and rst_n in the scope where they are used.
`ifndef ISING_METROPOLIS_UPDATE_CORE_ASSERT_SVH
`define ISING_METROPOLIS_UPDATE_CORE_ASSERT_SVH

// Consequent checked at the same clock edge as the antecedent.
`define IMU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define IMU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/imu_pkg.sv
// Package of the Ising Metropolis update core: field widths, codes and reset constants.
// No dependencies; the interfaces, the core and the checker import it.
`default_nettype none

package imu_pkg;

    localparam int ROWS_DEFAULT = 64;
    localparam int COLS_DEFAULT = 64;

    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int UNIFORM_W  = 16;
    localparam int CFG_W      = 16;
    localparam int THR_W      = 16;
    localparam int THR_N      = 10;
    localparam int THR_IDX_W  = 4;
    localparam int DELTA_W    = 20;
    localparam int SPIN_SUM_W = 14;
    localparam int ENERGY_W   = 48;
    localparam int STEP_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Operation codes of an input item.
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_C    = 3'd4;

    localparam logic signed [CFG_W-1:0] COUPLING_RESET = 16'sd4096;

    localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    localparam logic signed [SPIN_SUM_W-1:0] SPIN_STEP = 14'sd2;

endpackage

`default_nettype wire

FILE: rtl/imu_if.sv
// Handshake channels of the Ising update core: the item channel and the result channel.
// Depends on imu_pkg for the field widths.
`default_nettype none

interface imu_req_if;
    import imu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic [UNIFORM_W-1:0] uniform;
    logic                 spin_value;

    modport source (output valid, op, row, col, uniform, spin_value, input ready);
    modport sink   (input valid, op, row, col, uniform, spin_value, output ready);
endinterface

interface imu_rsp_if;
    import imu_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic                         site_spin;
    logic signed [DELTA_W-1:0]    delta_energy;
    logic signed [SPIN_SUM_W-1:0] spin_sum;
    logic signed [ENERGY_W-1:0]   energy_sum;
    logic [STEP_W-1:0]            step_count;

    modport source (output valid, accepted, site_spin, delta_energy, spin_sum, energy_sum,
                    step_count, input ready);
    modport sink   (input valid, accepted, site_spin, delta_energy, spin_sum, energy_sum,
                    step_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/imu_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module imu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/ising_metropolis_update_core.sv
// Ising Metropolis update core. The block keeps a ROWS x COLS periodic lattice of spins in a
// row-wide memory (one word per lattice row) and applies single-site Metropolis updates. A
// step item reads the row above, the site row and the row below through the single read
// port, sums the four wrap-around neighbors, forms the energy change 2(Jn+h)s in Q4.12,
// accepts the flip when that change is at most zero or when the random value lies below the
// threshold chosen by spin and neighbor sum, and writes the site row back. A write item
// loads one spin. Every item yields one result transfer carrying the accept flag, the new
// site spin, the energy change and the running spin sum, energy sum and step count. Items
// are paced by the three row reads on the memory's one read port; the write-back of one
// item overlaps the first read of the next, and a one-entry input buffer and an output
// register let the next item transfer in while a result still waits. An item that finds
// the block idle passes from the input buffer through the idle, mid-row, down-row and
// evaluation states into the output register; an item that transfers in while the one
// before it is still being read waits in the buffer until that item's evaluation, and a
// stalled result holds back the items behind it for as long as the stall lasts. After
// reset a clearing pass writes every row and sets every spin to +1 (cold start); no item
// transfers during that pass, while configuration writes are taken. The user must write
// configuration only while no item is in flight; the block itself does not enforce it.
`default_nettype none

module ising_metropolis_update_core #(
    parameter int ROWS = imu_pkg::ROWS_DEFAULT,
    parameter int COLS = imu_pkg::COLS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    imu_req_if.sink                          req,
    imu_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [imu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [imu_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import imu_pkg::*;

    localparam int RAW = $clog2(ROWS);
    localparam int CW  = $clog2(COLS);

    // Sequencer states. A new item's first read is issued in the cycle that leaves idle
    // or in the evaluation cycle of the item before it.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MID   = 3'd2;
    localparam logic [2:0] S_DN    = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;

    // Configuration registers.
    logic signed [CFG_W-1:0] coupling_reg;
    logic signed [CFG_W-1:0] field_reg;
    logic [CFG_DATA_W-1:0]   thr_a_reg;
    logic [CFG_DATA_W-1:0]   thr_b_reg;
    logic [CFG_DATA_W/2-1:0] thr_c_reg;

    // Sequencer and clearing pass.
    logic [2:0]     state_reg;
    logic [2:0]     state_next;
    logic [RAW-1:0] clr_row_reg;

    // One-entry input buffer.
    logic                 buf_valid_reg;
    logic                 buf_op_reg;
    logic [ROW_W-1:0]     buf_row_reg;
    logic [COL_W-1:0]     buf_col_reg;
    logic [UNIFORM_W-1:0] buf_uniform_reg;
    logic                 buf_spin_reg;

    // Item being worked on.
    logic                 wk_op_reg;
    logic                 wk_in_range_reg;
    logic [RAW-1:0]       wk_row_reg;
    logic [RAW-1:0]       wk_up_reg;
    logic [RAW-1:0]       wk_dn_reg;
    logic [CW-1:0]        wk_col_reg;
    logic [UNIFORM_W-1:0] wk_uniform_reg;
    logic                 wk_spin_reg;
    logic                 up_bit_reg;
    logic [COLS-1:0]      mid_row_reg;

    // Last write-back, for forwarding to a read issued in the same cycle.
    logic            wb_valid_reg;
    logic [RAW-1:0]  wb_row_reg;
    logic [COLS-1:0] wb_data_reg;

    // Running totals.
    logic signed [SPIN_SUM_W-1:0] spin_total_reg;
    logic signed [SPIN_SUM_W-1:0] spin_total_next;
    logic signed [ENERGY_W-1:0]   energy_reg;
    logic signed [ENERGY_W-1:0]   energy_next;
    logic [STEP_W-1:0]            steps_reg;
    logic [STEP_W-1:0]            steps_next;

    // Output register.
    logic                         rsp_valid_reg;
    logic                         out_acc_reg;
    logic                         out_spin_reg;
    logic signed [DELTA_W-1:0]    out_delta_reg;
    logic signed [SPIN_SUM_W-1:0] out_spin_sum_reg;
    logic signed [ENERGY_W-1:0]   out_energy_reg;
    logic [STEP_W-1:0]            out_steps_reg;

    // Memory ports.
    logic            ram_we;
    logic [RAW-1:0]  ram_waddr;
    logic [COLS-1:0] ram_wdata;
    logic            ram_re;
    logic [RAW-1:0]  ram_raddr;
    logic [COLS-1:0] ram_rdata;

    logic           eval_fire;
    logic           start;
    logic           buf_in_range;
    logic [RAW-1:0] buf_row_idx;
    logic [RAW-1:0] buf_up;
    logic [RAW-1:0] buf_dn;

    logic [COLS-1:0] up_row;
    logic [CW-1:0]   col_lf;
    logic [CW-1:0]   col_rt;
    logic            s_bit;
    logic            dn_bit;
    logic [2:0]      up_cnt;
    logic            flip;
    logic            new_bit;
    logic [COLS-1:0] new_row;

    logic signed [3:0]         n_s;
    logic signed [DELTA_W-1:0] jn;
    logic signed [DELTA_W-1:0] half_delta;
    logic signed [DELTA_W-1:0] delta;
    logic signed [ENERGY_W:0]  e_wide;
    logic signed [ENERGY_W-1:0] e_sat;

    logic [THR_W-1:0]     thr_tab [THR_N];
    logic [THR_IDX_W-1:0] thr_idx;

    logic                      res_acc;
    logic                      res_spin;
    logic signed [DELTA_W-1:0] res_delta;

    imu_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_spin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The evaluation cycle finishes only when the output register can take the result.
    assign eval_fire = (state_reg == S_EVAL) && (!rsp_valid_reg || rsp.ready);
    assign start     = buf_valid_reg && ((state_reg == S_IDLE) || eval_fire);
    assign req.ready = (state_reg != S_CLEAR) && (!buf_valid_reg || start);

    // Site decode of the buffered item, with wrap-around rows.
    assign buf_in_range = (32'(buf_row_reg) < 32'(ROWS)) && (32'(buf_col_reg) < 32'(COLS));
    assign buf_row_idx  = RAW'(buf_row_reg);
    assign buf_up = (buf_row_idx == '0) ? RAW'(ROWS - 1) : buf_row_idx - 1'b1;
    assign buf_dn = (buf_row_idx == RAW'(ROWS - 1)) ? '0 : buf_row_idx + 1'b1;

    // The row above is read in the cycle the previous item writes back, so it may be stale.
    assign up_row = (wb_valid_reg && (wb_row_reg == wk_up_reg)) ? wb_data_reg : ram_rdata;

    // Evaluation: neighbors, energy change and acceptance.
    assign col_lf = (wk_col_reg == '0) ? CW'(COLS - 1) : wk_col_reg - 1'b1;
    assign col_rt = (wk_col_reg == CW'(COLS - 1)) ? '0 : wk_col_reg + 1'b1;
    assign s_bit  = mid_row_reg[wk_col_reg];
    assign dn_bit = ram_rdata[wk_col_reg];
    assign up_cnt = {2'b00, up_bit_reg} + {2'b00, dn_bit}
                  + {2'b00, mid_row_reg[col_lf]} + {2'b00, mid_row_reg[col_rt]};

    // Neighbor sum n = 2k - 4, where k counts the neighbors at +1.
    assign n_s        = signed'({up_cnt, 1'b0} - 4'd4);
    assign jn         = DELTA_W'(coupling_reg) * DELTA_W'(n_s);
    assign half_delta = jn + DELTA_W'(field_reg);
    assign delta      = s_bit ? (half_delta <<< 1) : -(half_delta <<< 1);

    assign thr_tab[0] = thr_a_reg[15:0];
    assign thr_tab[1] = thr_a_reg[31:16];
    assign thr_tab[2] = thr_a_reg[47:32];
    assign thr_tab[3] = thr_a_reg[63:48];
    assign thr_tab[4] = thr_b_reg[15:0];
    assign thr_tab[5] = thr_b_reg[31:16];
    assign thr_tab[6] = thr_b_reg[47:32];
    assign thr_tab[7] = thr_b_reg[63:48];
    assign thr_tab[8] = thr_c_reg[15:0];
    assign thr_tab[9] = thr_c_reg[31:16];

    assign thr_idx = s_bit ? (THR_IDX_W'(5) + THR_IDX_W'(up_cnt)) : THR_IDX_W'(up_cnt);
    assign flip    = delta[DELTA_W-1] || (delta == '0) || (wk_uniform_reg < thr_tab[thr_idx]);

    // Saturating energy accumulation.
    assign e_wide = {energy_reg[ENERGY_W-1], energy_reg} + (ENERGY_W + 1)'(delta);
    assign e_sat  = (e_wide[ENERGY_W] != e_wide[ENERGY_W-1])
                  ? (e_wide[ENERGY_W] ? ENERGY_MIN : ENERGY_MAX)
                  : e_wide[ENERGY_W-1:0];

    always_comb
    begin
        new_bit         = s_bit;
        res_acc         = 1'b0;
        res_spin        = 1'b0;
        res_delta       = '0;
        spin_total_next = spin_total_reg;
        energy_next     = energy_reg;
        steps_next      = steps_reg;
        if (wk_in_range_reg)
        begin
            case (wk_op_reg)
                OP_WRITE:
                begin
                    new_bit  = wk_spin_reg;
                    res_acc  = 1'b1;
                    res_spin = wk_spin_reg;
                    if (wk_spin_reg != s_bit)
                    begin
                        spin_total_next = wk_spin_reg ? spin_total_reg + SPIN_STEP
                                                      : spin_total_reg - SPIN_STEP;
                    end
                end
                OP_STEP:
                begin
                    res_delta = delta;
                    res_acc   = flip;
                    new_bit   = s_bit ^ flip;
                    res_spin  = s_bit ^ flip;
                    if (flip)
                    begin
                        spin_total_next = s_bit ? spin_total_reg - SPIN_STEP
                                                : spin_total_reg + SPIN_STEP;
                        energy_next     = e_sat;
                    end
                    if (steps_reg != '1)
                    begin
                        steps_next = steps_reg + 1'b1;
                    end
                end
                default:
                begin
                    new_bit = s_bit;
                end
            endcase
        end
    end

    always_comb
    begin
        new_row             = mid_row_reg;
        new_row[wk_col_reg] = new_bit;
    end

    // Memory port selection: the clearing pass owns the write port after reset.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_row_reg;
            ram_wdata = '1;
        end
        else
        begin
            ram_we    = eval_fire && wk_in_range_reg;
            ram_waddr = wk_row_reg;
            ram_wdata = new_row;
        end
    end

    always_comb
    begin
        ram_re    = start || (state_reg == S_MID) || (state_reg == S_DN);
        ram_raddr = buf_up;
        if (state_reg == S_MID)
        begin
            ram_raddr = wk_row_reg;
        end
        else if (state_reg == S_DN)
        begin
            ram_raddr = wk_dn_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_row_reg == RAW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MID;
                end
            end
            S_MID:   state_next = S_DN;
            S_DN:    state_next = S_EVAL;
            S_EVAL:
            begin
                if (start)
                begin
                    state_next = S_MID;
                end
                else if (eval_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and running totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_row_reg    <= '0;
            buf_valid_reg  <= 1'b0;
            wb_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            coupling_reg   <= COUPLING_RESET;
            field_reg      <= '0;
            thr_a_reg      <= '0;
            thr_b_reg      <= '0;
            thr_c_reg      <= '0;
            spin_total_reg <= SPIN_SUM_W'(ROWS * COLS);
            energy_reg     <= '0;
            steps_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end

            if (req.valid && req.ready)
            begin
                buf_valid_reg <= 1'b1;
            end
            else if (start)
            begin
                buf_valid_reg <= 1'b0;
            end

            wb_valid_reg <= (state_reg != S_CLEAR) && ram_we;

            if (eval_fire)
            begin
                rsp_valid_reg  <= 1'b1;
                spin_total_reg <= spin_total_next;
                energy_reg     <= energy_next;
                steps_reg      <= steps_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COUPLING: coupling_reg <= signed'(cfg_data[CFG_W-1:0]);
                    REG_FIELD:    field_reg    <= signed'(cfg_data[CFG_W-1:0]);
                    REG_THR_A:    thr_a_reg    <= cfg_data;
                    REG_THR_B:    thr_b_reg    <= cfg_data;
                    REG_THR_C:    thr_c_reg    <= cfg_data[CFG_DATA_W/2-1:0];
                    default:      thr_c_reg    <= thr_c_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            buf_op_reg      <= req.op;
            buf_row_reg     <= req.row;
            buf_col_reg     <= req.col;
            buf_uniform_reg <= req.uniform;
            buf_spin_reg    <= req.spin_value;
        end

        if (start)
        begin
            wk_op_reg       <= buf_op_reg;
            wk_in_range_reg <= buf_in_range;
            wk_row_reg      <= buf_row_idx;
            wk_up_reg       <= buf_up;
            wk_dn_reg       <= buf_dn;
            wk_col_reg      <= CW'(buf_col_reg);
            wk_uniform_reg  <= buf_uniform_reg;
            wk_spin_reg     <= buf_spin_reg;
        end

        if (state_reg == S_MID)
        begin
            up_bit_reg <= up_row[wk_col_reg];
        end
        if (state_reg == S_DN)
        begin
            mid_row_reg <= ram_rdata;
        end

        if (ram_we)
        begin
            wb_row_reg  <= ram_waddr;
            wb_data_reg <= ram_wdata;
        end

        if (eval_fire)
        begin
            out_acc_reg      <= res_acc;
            out_spin_reg     <= res_spin;
            out_delta_reg    <= res_delta;
            out_spin_sum_reg <= spin_total_next;
            out_energy_reg   <= energy_next;
            out_steps_reg    <= steps_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.accepted     = out_acc_reg;
    assign rsp.site_spin    = out_spin_reg;
    assign rsp.delta_energy = out_delta_reg;
    assign rsp.spin_sum     = out_spin_sum_reg;
    assign rsp.energy_sum   = out_energy_reg;
    assign rsp.step_count   = out_steps_reg;

endmodule

`default_nettype wire

FILE: rtl/imu_checker.sv
// Port-level checker of the Ising update core, bound to the top level below.
// Depends on imu_pkg and on ising_metropolis_update_core_assert.svh.
`default_nettype none
`include "ising_metropolis_update_core_assert.svh"

module imu_checker #(
    parameter int ROWS = imu_pkg::ROWS_DEFAULT,
    parameter int COLS = imu_pkg::COLS_DEFAULT
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  req_ready,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic                                  rsp_accepted,
    input logic                                  rsp_site_spin,
    input logic signed [imu_pkg::DELTA_W-1:0]    rsp_delta_energy,
    input logic signed [imu_pkg::SPIN_SUM_W-1:0] rsp_spin_sum,
    input logic signed [imu_pkg::ENERGY_W-1:0]   rsp_energy_sum,
    input logic [imu_pkg::STEP_W-1:0]            rsp_step_count
);

    import imu_pkg::*;

    // A sum of ROWS*COLS values of plus or minus one has the parity of the site count.
    localparam logic SUM_LSB = 1'((ROWS * COLS) % 2);

    localparam int PAYLOAD_W = 2 + DELTA_W + SPIN_SUM_W + ENERGY_W + STEP_W;

    logic [PAYLOAD_W-1:0] rsp_payload;

    assign rsp_payload = {rsp_accepted, rsp_site_spin, rsp_delta_energy, rsp_spin_sum,
                          rsp_energy_sum, rsp_step_count};

    // A stalled result stays on the port unchanged.
    `IMU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed while stalled")

    // The clearing pass after reset takes no items.
    `IMU_ASSERT_SAME(a_clear_blocks, $rose(rst_n), !req_ready, "item taken during clearing pass")

    // A flip that lowers the energy is always taken.
    `IMU_ASSERT_SAME(a_downhill_taken, rsp_valid && rsp_delta_energy[DELTA_W-1], rsp_accepted, "negative energy change rejected")

    // Spin sum keeps the parity of the site count.
    `IMU_ASSERT_SAME(a_sum_parity, rsp_valid, rsp_spin_sum[0] == SUM_LSB, "spin sum parity broken")

endmodule

bind ising_metropolis_update_core imu_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_imu_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_accepted     (rsp.accepted),
    .rsp_site_spin    (rsp.site_spin),
    .rsp_delta_energy (rsp.delta_energy),
    .rsp_spin_sum     (rsp.spin_sum),
    .rsp_energy_sum   (rsp.energy_sum),
    .rsp_step_count   (rsp.step_count)
);

`default_nettype wire
